// File: src/ground_sensor_window_classifier_top_macros.svh
// assertion macros for the floor classifier
`ifndef GROUND_SENSOR_WINDOW_CLASSIFIER_TOP_MACROS_SVH
`define GROUND_SENSOR_WINDOW_CLASSIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GSWC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define GSWC_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define GSWC_ASSERT(label, clk, rst, prop)
`define GSWC_ASSERT_RST(label, clk, prop)
`endif

`endif

// File: src/gswc_pkg.sv
`timescale 1ns / 1ps

package gswc_pkg;

   localparam int WINDOW = 10;

   localparam int LEVEL_W     = 12;
   localparam int CNT_FIELD_W = 5;
   localparam int CLASS_W     = 2;

   localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int COUNT_W = $clog2(3 * WINDOW + 1);
   localparam int CMP_W   = (COUNT_W > CNT_FIELD_W) ? COUNT_W : CNT_FIELD_W;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [LEVEL_W-1:0]     BLACK_THR_RESET = 12'd82;
   localparam logic [LEVEL_W-1:0]     WHITE_THR_RESET = 12'd3973;
   localparam logic [CNT_FIELD_W-1:0] DECISION_RESET  = 5'd8;

   localparam logic [1:0] CSR_BLACK_THR = 2'd0;
   localparam logic [1:0] CSR_WHITE_THR = 2'd1;
   localparam logic [1:0] CSR_DECISION  = 2'd2;

   localparam logic [CLASS_W-1:0] CLASS_BLACK = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_GRAY  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_WHITE = 2'd2;

   typedef struct packed {
      logic [LEVEL_W-1:0] white_threshold;
      logic [LEVEL_W-1:0] black_threshold;
   } thr_type;

   typedef struct packed {
      logic [2:0] white;
      logic [2:0] black;
   } mark_type;

   typedef struct packed {
      logic [CNT_FIELD_W-1:0] white_total;
      logic [CNT_FIELD_W-1:0] black_total;
      logic [CLASS_W-1:0]     floor_class;
   } result_type;

   function automatic logic [1:0] ones3(input logic [2:0] v);
      ones3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
   endfunction

endpackage

// File: src/gswc_mark.sv
`timescale 1ns / 1ps

module gswc_mark (
   input  logic [gswc_pkg::LEVEL_W-1:0] left_level,
   input  logic [gswc_pkg::LEVEL_W-1:0] center_level,
   input  logic [gswc_pkg::LEVEL_W-1:0] right_level,
   input  gswc_pkg::thr_type            thr,
   output gswc_pkg::mark_type           marks
);
   import gswc_pkg::*;

   logic [LEVEL_W-1:0] level [3];

   assign level[0] = left_level;
   assign level[1] = center_level;
   assign level[2] = right_level;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         marks.black[i] = level[i] < thr.black_threshold;
         marks.white[i] = !(level[i] < thr.black_threshold) &&
                          (level[i] > thr.white_threshold);
      end
   end

endmodule

// File: src/gswc_window.sv
`timescale 1ns / 1ps

module gswc_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  gswc_pkg::mark_type                marks,
   input  logic [gswc_pkg::CNT_FIELD_W-1:0]  decision_count,
   output gswc_pkg::result_type              result
);
   import gswc_pkg::*;

   mark_type           window_ff [WINDOW];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [COUNT_W-1:0] black_ff;
   logic [COUNT_W-1:0] black_in;
   logic [COUNT_W-1:0] white_ff;
   logic [COUNT_W-1:0] white_in;
   logic               full;
   mark_type           oldest;
   logic [CMP_W-1:0]   black_cmp;
   logic [CMP_W-1:0]   white_cmp;
   logic [CMP_W-1:0]   limit_cmp;

   assign full   = (fill_ff == FILL_W'(WINDOW));
   assign oldest = window_ff[wr_ptr_ff];

   always_comb begin
      black_in  = black_ff + COUNT_W'(ones3(marks.black));
      white_in  = white_ff + COUNT_W'(ones3(marks.white));
      fill_in   = fill_ff;
      wr_ptr_in = (wr_ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (full) begin
         black_in = black_in - COUNT_W'(ones3(oldest.black));
         white_in = white_in - COUNT_W'(ones3(oldest.white));
      end else begin
         fill_in = fill_ff + 1'b1;
      end
   end

   assign black_cmp = CMP_W'(black_in);
   assign white_cmp = CMP_W'(white_in);
   assign limit_cmp = CMP_W'(decision_count);

   always_comb begin
      if (black_cmp > limit_cmp) begin
         result.floor_class = CLASS_BLACK;
      end else if (white_cmp > limit_cmp) begin
         result.floor_class = CLASS_WHITE;
      end else begin
         result.floor_class = CLASS_GRAY;
      end
      result.black_total = black_cmp[CNT_FIELD_W-1:0];
      result.white_total = white_cmp[CNT_FIELD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (step) begin
         window_ff[wr_ptr_ff] <= marks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
         black_ff  <= '0;
         white_ff  <= '0;
      end else if (step) begin
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
         black_ff  <= black_in;
         white_ff  <= white_in;
      end
   end

`include "ground_sensor_window_classifier_top_macros.svh"

   `GSWC_ASSERT(a_fill_bound, clock, reset, fill_ff <= FILL_W'(WINDOW))
   `GSWC_ASSERT(a_ptr_tracks_fill, clock, reset, full || (FILL_W'(wr_ptr_ff) == fill_ff))
   `GSWC_ASSERT(a_totals_bound, clock, reset,
                (CMP_W'(black_ff) + CMP_W'(white_ff)) <= CMP_W'(3 * fill_ff))

endmodule

// File: src/ground_sensor_window_classifier_top.sv
`timescale 1ns / 1ps
// an accepted req transfer is registered in the input stage, then in the response stage, before rsp
// throughput: one item per cycle, sustained while rsp_tready stays high
// the window bookkeeping updates once per item in the second stage
// reset (synchronous, active high): thresholds return to 82 / 3973 / 8,
// the window empties and both pipeline stages drop their items

module ground_sensor_window_classifier_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // left_level [11:0], center_level [23:12], right_level [35:24], zero [39:36]
   input  logic [gswc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // floor_class [1:0], black_total [6:2], white_total [11:7], zero [15:12]
   output logic [gswc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [gswc_pkg::LEVEL_W-1:0]       csr_data
);
   import gswc_pkg::*;

   thr_type                thr_ff;
   logic [CNT_FIELD_W-1:0] decision_ff;

   logic                   stage_valid_ff;
   logic [LEVEL_W-1:0]     left_ff;
   logic [LEVEL_W-1:0]     center_ff;
   logic [LEVEL_W-1:0]     right_ff;

   logic                   rsp_valid_ff;
   result_type             rsp_ff;

   logic                   advance;
   logic                   step;
   mark_type               marks;
   result_type             result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.black_threshold <= BLACK_THR_RESET;
         thr_ff.white_threshold <= WHITE_THR_RESET;
         decision_ff            <= DECISION_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BLACK_THR: thr_ff.black_threshold <= csr_data;
            CSR_WHITE_THR: thr_ff.white_threshold <= csr_data;
            CSR_DECISION:  decision_ff <= csr_data[CNT_FIELD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = stage_valid_ff && advance;
   assign req_tready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         left_ff   <= req_tdata[LEVEL_W-1:0];
         center_ff <= req_tdata[2*LEVEL_W-1:LEVEL_W];
         right_ff  <= req_tdata[3*LEVEL_W-1:2*LEVEL_W];
      end
   end

   gswc_mark u_mark (
      .left_level   (left_ff),
      .center_level (center_ff),
      .right_level  (right_ff),
      .thr          (thr_ff),
      .marks        (marks)
   );

   gswc_window u_window (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .marks          (marks),
      .decision_count (decision_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_ff};

`include "ground_sensor_window_classifier_top_macros.svh"

   `GSWC_ASSERT_RST(a_reset_empties, clock, reset |=> (!rsp_valid_ff && !stage_valid_ff))
   `GSWC_ASSERT(a_step_fills_rsp, clock, reset, step |=> rsp_valid_ff)
   `GSWC_ASSERT(a_stall_holds_stage, clock, reset,
                (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(left_ff)))

endmodule

// File: tb/floor_class_checker.sv
`timescale 1ns / 1ps

module floor_class_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [gswc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [gswc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [gswc_pkg::LEVEL_W-1:0]      csr_data,
   output int unsigned                       fail_count,
   output int unsigned                       results_due
);
   import gswc_pkg::*;

   localparam int PEND_DEPTH = 16;
   localparam int PEND_W     = $clog2(PEND_DEPTH);

   logic [LEVEL_W-1:0]     black_thr = BLACK_THR_RESET;
   logic [LEVEL_W-1:0]     white_thr = WHITE_THR_RESET;
   logic [CNT_FIELD_W-1:0] decision  = DECISION_RESET;

   mark_type    window_marks [WINDOW];
   int unsigned fill_level  = 0;
   int unsigned oldest_idx  = 0;
   int unsigned black_run   = 0;
   int unsigned white_run   = 0;
   int unsigned fail_total  = 0;
   int unsigned due_total   = 0;

   result_type        pending [PEND_DEPTH];
   logic [PEND_W-1:0] pend_wr    = '0;
   logic [PEND_W-1:0] pend_rd    = '0;
   int unsigned       pend_count = 0;

   assign fail_count  = fail_total;
   assign results_due = due_total;

   function automatic mark_type mark_levels(input logic [REQ_DATA_W-1:0] data);
      mark_type           m;
      logic [LEVEL_W-1:0] lv;
      m = '0;
      for (int ch = 0; ch < 3; ch++) begin
         lv = data[ch*LEVEL_W +: LEVEL_W];
         if (lv < black_thr) begin
            m.black[ch] = 1'b1;
         end else if (lv > white_thr) begin
            m.white[ch] = 1'b1;
         end
      end
      return m;
   endfunction

   task automatic classify_sample(input logic [REQ_DATA_W-1:0] data);
      mark_type         m;
      mark_type         old;
      logic [PTR_W-1:0] slot;
      result_type       r;
      m = mark_levels(data);
      if (fill_level < WINDOW) begin
         slot = PTR_W'((oldest_idx + fill_level) % WINDOW);
         fill_level++;
      end else begin
         slot = PTR_W'(oldest_idx);
         old = window_marks[slot];
         black_run -= $countones(old.black);
         white_run -= $countones(old.white);
         oldest_idx = (int'(slot) + 1) % WINDOW;
      end
      window_marks[slot] = m;
      black_run += $countones(m.black);
      white_run += $countones(m.white);
      if (black_run > decision) begin
         r.floor_class = CLASS_BLACK;
      end else if (white_run > decision) begin
         r.floor_class = CLASS_WHITE;
      end else begin
         r.floor_class = CLASS_GRAY;
      end
      r.black_total = black_run[CNT_FIELD_W-1:0];
      r.white_total = white_run[CNT_FIELD_W-1:0];
      if (pend_count == PEND_DEPTH) begin
         if (fail_total < 10) begin
            $display("too many results outstanding");
         end
         fail_total++;
      end else begin
         pending[pend_wr] = r;
         pend_wr = pend_wr + 1'b1;
         pend_count++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      result_type got;
      result_type want;
      if (reset) begin
         black_thr  = BLACK_THR_RESET;
         white_thr  = WHITE_THR_RESET;
         decision   = DECISION_RESET;
         fill_level = 0;
         oldest_idx = 0;
         black_run  = 0;
         white_run  = 0;
         pend_wr    = '0;
         pend_rd    = '0;
         pend_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLACK_THR: black_thr = csr_data;
               CSR_WHITE_THR: white_thr = csr_data;
               CSR_DECISION:  decision  = csr_data[CNT_FIELD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (pend_count == 0) begin
               if (fail_total < 10) begin
                  $display("unexpected rsp transfer: class %0d black %0d white %0d",
                           got.floor_class, got.black_total, got.white_total);
               end
               fail_total++;
            end else begin
               want = pending[pend_rd];
               pend_rd = pend_rd + 1'b1;
               pend_count--;
               if (got.floor_class !== want.floor_class ||
                   got.black_total !== want.black_total ||
                   got.white_total !== want.white_total) begin
                  if (fail_total < 10) begin
                     $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              want.floor_class, want.black_total, want.white_total,
                              got.floor_class, got.black_total, got.white_total);
                  end
                  fail_total++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            classify_sample(req_tdata);
         end
      end
      due_total = pend_count;
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import gswc_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef enum int {SCENE_DARK, SCENE_LIGHT, SCENE_EDGE, SCENE_NOISE} scene_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [1:0]             csr_index;
   logic [LEVEL_W-1:0]     csr_data;

   int unsigned fail_count;
   int unsigned results_due;

   logic [LEVEL_W-1:0] cur_black = BLACK_THR_RESET;
   logic [LEVEL_W-1:0] cur_white = WHITE_THR_RESET;
   scene_type          scene     = SCENE_NOISE;
   int                 gap_rate   = 4;
   int                 stall_rate = 4;
   int                 stall_left = 0;

   always #2 clock = ~clock;

   ground_sensor_window_classifier_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   floor_class_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   // receiver back-pressure in short bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_rate != 0 && $urandom_range(stall_rate - 1, 0) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(3, 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [LEVEL_W-1:0] pick_level();
      logic [LEVEL_W-1:0] v;
      v = LEVEL_W'($urandom);
      if ($urandom_range(9, 0) < 8) begin
         case (scene)
            SCENE_DARK: begin
               if (cur_black != 0) v = LEVEL_W'($urandom_range(int'(cur_black) - 1, 0));
            end
            SCENE_LIGHT: begin
               if (cur_white != 12'hFFF) v = LEVEL_W'($urandom_range(4095, int'(cur_white) + 1));
            end
            SCENE_EDGE: begin
               v = ($urandom_range(1, 0) ? cur_black : cur_white)
                   + LEVEL_W'($urandom_range(2, 0)) - 12'd1;
            end
            default: ;
         endcase
      end
      return v;
   endfunction

   task automatic send_levels(input logic [LEVEL_W-1:0] left, center, right);
      if (gap_rate != 0 && $urandom_range(gap_rate - 1, 0) == 0) begin
         repeat ($urandom_range(4, 1)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, right, center, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_scene_sample();
      if ($urandom_range(7, 0) == 0) scene = scene_type'($urandom_range(3, 0));
      send_levels(pick_level(), pick_level(), pick_level());
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [LEVEL_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_BLACK_THR) cur_black = value;
      if (idx == CSR_WHITE_THR) cur_white = value;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input logic [LEVEL_W-1:0] black_thr, white_thr, decision_word,
                            input int count, input int gaps, input int stalls);
      settle();
      write_reg(CSR_BLACK_THR, black_thr);
      write_reg(CSR_WHITE_THR, white_thr);
      write_reg(CSR_DECISION, decision_word);
      gap_rate   = gaps;
      stall_rate = stalls;
      repeat (count) send_scene_sample();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_BLACK_THR;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window filling, threshold edges, oldest sample dropping
      send_levels(12'd0, 12'd0, 12'd0);
      send_levels(12'hFFF, 12'hFFF, 12'hFFF);
      send_levels(12'd81, 12'd82, 12'd83);
      send_levels(12'd3972, 12'd3973, 12'd3974);
      send_levels(12'd0, 12'hFFF, 12'd2048);
      send_levels(12'd0, 12'd0, 12'd0);
      send_levels(12'd0, 12'd0, 12'd0);
      send_levels(12'hAAA, 12'h555, 12'hAAA);
      send_levels(12'hFFF, 12'hFFF, 12'hFFF);
      send_levels(12'hFFF, 12'hFFF, 12'hFFF);
      send_levels(12'hFFF, 12'hFFF, 12'hFFF);
      send_levels(12'h555, 12'hAAA, 12'h555);
      send_levels(12'hFFF, 12'hFFF, 12'hFFF);
      send_levels(12'hFFF, 12'hFFF, 12'hFFF);
      send_levels(12'd2048, 12'd2048, 12'd2048);
      send_levels(12'd2048, 12'd2048, 12'd2048);
      send_levels(12'd0, 12'd81, 12'd3974);
      settle();
      // unused register index must change nothing
      write_reg(CSR_UNUSED, 12'hFFF);
      send_levels(12'd81, 12'd82, 12'd3974);
      send_levels(12'd0, 12'hFFF, 12'd3973);
      send_levels(12'd1, 12'hFFE, 12'd82);

      run_phase(12'd123, 12'd3481, 12'd10, 120, 4, 6);
      run_phase(12'hFFF, 12'd0, 12'd0, 110, 3, 3);
      run_phase(12'd0, 12'hFFF, 12'd30, 100, 5, 5);
      run_phase(12'd3000, 12'd1000, 12'hFE5, 120, 0, 0);
      run_phase(LEVEL_W'($urandom), LEVEL_W'($urandom), 12'h01F, 100, 2, 4);
      run_phase(12'd2048, 12'd2047, {7'($urandom), 5'($urandom_range(30, 0))}, 120, 6, 3);
      run_phase(BLACK_THR_RESET, WHITE_THR_RESET, 12'(DECISION_RESET), 150, 0, 0);

      settle();
      if (fail_count == 0) begin
         $display("ground_sensor_window_classifier_top test passed");
      end else begin
         $display("ground_sensor_window_classifier_top test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("ground_sensor_window_classifier_top test failed");
      $finish;
   end

endmodule
